>>> hdl/lphm_pkg.sv
`default_nettype none
package lphm_pkg;

  localparam int CAP_LOG2_W = 4;
  localparam int MODE_W     = 2;
  localparam int CFG_DATA_W = 4;
  localparam int BITS_W     = 5;
  localparam int STATUS_W   = 3;

  localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_RESET = 4'd3;

  localparam logic [31:0] FIB_LO = 32'h7F4A7C15;
  localparam logic [31:0] FIB_HI = 32'h9E3779B9;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_t;

  typedef enum logic {
    CFG_CAP_LOG2    = 1'b0,
    CFG_UPDATE_MODE = 1'b1
  } cfg_index_t;

  typedef enum logic [MODE_W-1:0] {
    UPD_REPLACE = 2'd0,
    UPD_KEEP    = 2'd1,
    UPD_REFUSE  = 2'd2
  } update_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_ABSENT   = 3'd1,
    ST_INSERTED = 3'd2,
    ST_REPLACED = 3'd3,
    ST_KEPT     = 3'd4,
    ST_REFUSED  = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HOME,
    S_LOOK,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

>>> hdl/lphm_hash.sv
`default_nettype none
module lphm_hash #(
  parameter int KEY_BITS = 16,
  parameter int LW       = 10
) (
  input  wire logic                        clk,
  input  wire logic [KEY_BITS-1:0]         key,
  input  wire logic [lphm_pkg::BITS_W-1:0] bits,
  output logic      [LW-1:0]               home
);
  import lphm_pkg::*;

  localparam int PW = KEY_BITS + 32;

  logic [PW-1:0] prod_lo;
  logic [31:0]   prod_hi;
  logic [31:0]   top_word;
  logic [5:0]    shamt;

  // partial products of key with the two 32-bit halves of the 64-bit golden-ratio constant
  always_ff @(posedge clk) begin
    prod_lo <= PW'(key) * PW'(FIB_LO);
    prod_hi <= 32'(PW'(key) * PW'(FIB_HI));
  end

  always_comb begin
    top_word = prod_hi + 32'(prod_lo >> 32);
    shamt    = 6'd32 - 6'(bits);
    home     = LW'(top_word >> shamt);
  end

endmodule
`default_nettype wire

>>> hdl/lphm_mem.sv
`default_nettype none
module lphm_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/linear_probe_hash_map.sv
`default_nettype none
// Key/value map, open addressing with linear probing over one slot memory of
// MAX_SLOTS entries holding {key, value}. After reset the block runs a clearing
// pass, writing one empty key per cycle, and accepts no item until it ends;
// configuration writes are taken at any time. Each accepted item is hashed
// (Fibonacci hashing, key register then product register), its home slot is
// loaded into the probe pointer, and 1 up to the capacity in use slots are
// probed, one per cycle through the single read port of the slot memory. A
// finish state decides and writes back, holding while the last result is not
// taken, then idles to take the next item. A zero key goes straight to finish.
// Results wait in an output register while the next item is accepted.
module linear_probe_hash_map #(
  parameter int MAX_SLOTS  = 1024,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire lphm_pkg::op_t                   op,
  input  wire logic [KEY_BITS-1:0]             key,
  input  wire logic [VALUE_BITS-1:0]           value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [VALUE_BITS-1:0]           value_out,
  output lphm_pkg::status_t                    status,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire lphm_pkg::cfg_index_t            cfg_index,
  input  wire logic [lphm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lphm_pkg::*;

  localparam int AW   = $clog2(MAX_SLOTS);
  localparam int MAXL = $clog2(MAX_SLOTS + 1) - 1;
  localparam int LW   = MAXL;
  localparam int CW   = LW + 1;
  localparam int OW   = $clog2(MAX_SLOTS + 1);
  localparam int NW   = OW + 2;
  localparam int DW   = KEY_BITS + VALUE_BITS;

  localparam logic [AW-1:0] ADDR_MASK = AW'(MAX_SLOTS - 1);

  state_t state, state_next;

  logic [CAP_LOG2_W-1:0] cap_log2;
  logic [MODE_W-1:0]     upd_mode;

  op_t                   op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  zkey;

  logic [BITS_W-1:0] bits;
  logic [CW-1:0]     cap;
  logic [LW-1:0]     home;
  logic [LW-1:0]     ptr;
  logic [LW-1:0]     ptr_wrap;
  logic [CW-1:0]     ptr_inc;
  logic [CW-1:0]     cnt;
  logic              rd_valid;
  logic [LW-1:0]     rd_pos;
  logic [DW-1:0]     rd_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic              hit, hole, last, stop;

  logic                  found, empty;
  logic [LW-1:0]         pos;
  logic [VALUE_BITS-1:0] old_val;

  logic [AW-1:0] clr_addr;
  logic [OW-1:0] occ;
  logic [NW-1:0] need;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic                  out_free;
  logic                  res_load;
  logic                  occ_inc;
  logic [VALUE_BITS-1:0] res_val;
  status_t               res_st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2 <= CAP_LOG2_RESET;
      upd_mode <= UPD_REPLACE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CAP_LOG2:    cap_log2 <= cfg_data;
        CFG_UPDATE_MODE: upd_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cap_log2 == '0) begin
      bits = BITS_W'(1);
    end else if (BITS_W'(cap_log2) > BITS_W'(MAXL)) begin
      bits = BITS_W'(MAXL);
    end else begin
      bits = BITS_W'(cap_log2);
    end
    cap = CW'(1) << bits;
  end

  lphm_hash #(
    .KEY_BITS(KEY_BITS),
    .LW      (LW)
  ) u_hash (
    .clk (clk),
    .key (key_r),
    .bits(bits),
    .home(home)
  );

  lphm_mem #(
    .DEPTH(MAX_SLOTS),
    .AW   (AW),
    .DW   (DW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rd_data)
  );

  assign rd_key    = rd_data[DW-1:VALUE_BITS];
  assign rd_val    = rd_data[VALUE_BITS-1:0];
  assign ptr_inc   = CW'(ptr) + CW'(1);
  assign ptr_wrap  = (ptr_inc == cap) ? '0 : LW'(ptr_inc);
  assign mem_raddr = AW'(ptr) & ADDR_MASK;
  assign hit       = rd_key == key_r;
  assign hole      = rd_key == '0;
  assign last      = cnt == (cap - CW'(1));
  assign stop      = hit || hole || last;
  assign need      = ((NW'(occ) + NW'(1)) * NW'(3)) >> 1;
  assign out_free  = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_MASK) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = (key == '0) ? S_FINISH : S_HASH;
      end
      S_HASH: state_next = S_HOME;
      S_HOME: state_next = S_LOOK;
      S_LOOK: begin
        if (rd_valid && stop) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and write-back decision
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(pos) & ADDR_MASK;
    mem_wdata = {key_r, val_r};
    res_load  = 1'b0;
    occ_inc   = 1'b0;
    res_val   = '0;
    res_st    = ST_ABSENT;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: in_ready = 1'b1;
      S_FINISH: begin
        res_load = out_free;
        if (zkey) begin
          res_st = (op_r == OP_SET) ? ST_REFUSED : ST_ABSENT;
        end else if (op_r == OP_GET) begin
          if (found) begin
            res_st  = ST_HIT;
            res_val = old_val;
          end
        end else if (found) begin
          unique case (upd_mode)
            UPD_REPLACE: begin
              mem_we  = out_free;
              res_st  = ST_REPLACED;
              res_val = val_r;
            end
            UPD_KEEP: begin
              res_st  = ST_KEPT;
              res_val = old_val;
            end
            default: res_st = ST_REFUSED;
          endcase
        end else if (empty && (need < NW'(cap))) begin
          mem_we  = out_free;
          occ_inc = out_free;
          res_st  = ST_INSERTED;
          res_val = val_r;
        end else begin
          res_st = ST_FULL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      occ       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == S_LOOK) && (state_next == S_LOOK);
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (occ_inc) occ <= occ + OW'(1);
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= op;
      key_r <= key;
      val_r <= value;
      zkey  <= key == '0;
    end
    if (state == S_HOME) begin
      ptr <= home;
      cnt <= '0;
    end
    if (state == S_LOOK) begin
      ptr    <= ptr_wrap;
      rd_pos <= ptr;
      if (rd_valid) begin
        if (stop) begin
          found   <= hit;
          empty   <= hole;
          pos     <= rd_pos;
          old_val <= rd_val;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
    end
    if (res_load) begin
      value_out <= res_val;
      status    <= res_st;
    end
  end

endmodule
`default_nettype wire
